[hw/rtl/unicode_keystroke_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// Unicode keystroke sequencer assertion macros
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef UNICODE_KEYSTROKE_SEQUENCER_DEFINES_SVH
`define UNICODE_KEYSTROKE_SEQUENCER_DEFINES_SVH
`ifndef ASSERT_OFF
`define UKS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define UKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define UKS_ASSERT_SAME(label, clk, rst, ante, cons)
`define UKS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/uks_pkg.sv]
// ----------------------------------------------------------------------------
// Unicode keystroke sequencer package
// Shared constants, types, the digit to key usage mapping and the host sequence lengths.
// ----------------------------------------------------------------------------
`default_nettype none

package uks_pkg;

   localparam int HEX_DIGITS = 8;
   localparam int MIN_DIGITS = 4;
   localparam int CP_W       = 32;
   localparam int NIB_W      = 4;
   localparam int HOLD_W     = HEX_DIGITS * NIB_W;
   localparam int IDX_W      = $clog2(HEX_DIGITS);

   localparam logic [1:0] OS_LINUX   = 2'd0;
   localparam logic [1:0] OS_WINDOWS = 2'd1;
   localparam logic [1:0] OS_OSX     = 2'd2;
   localparam logic [1:0] OS_OTHER   = 2'd3;

   localparam logic [2:0] MOD_NONE  = 3'h0;
   localparam logic [2:0] MOD_CTRL  = 3'h1;
   localparam logic [2:0] MOD_SHIFT = 3'h2;
   localparam logic [2:0] MOD_ALT   = 3'h4;

   localparam logic [7:0] USAGE_NONE   = 8'h00;
   localparam logic [7:0] USAGE_A      = 8'h04;
   localparam logic [7:0] USAGE_U      = 8'h18;
   localparam logic [7:0] USAGE_1      = 8'h1E;
   localparam logic [7:0] USAGE_0      = 8'h27;
   localparam logic [7:0] USAGE_SPACE  = 8'h2C;
   localparam logic [7:0] USAGE_KP_ADD = 8'h57;
   localparam logic [7:0] USAGE_KP_1   = 8'h59;
   localparam logic [7:0] USAGE_KP_0   = 8'h62;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_DIGIT = 4'b0100,
      ST_END   = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic emit_start;
      logic emit_digit;
      logic emit_end;
      logic step_inc;
      logic step_clr;
      logic digit_next;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_empty;
      logic end_empty;
      logic start_step_last;
      logic digit_step_last;
      logic end_step_last;
      logic digit_last;
   } dp_status_type;

   function automatic logic [7:0] digit_usage(input logic [3:0] d, input logic keypad);
      logic [7:0] usage;
      if (d == 4'h0) begin
         usage = keypad ? USAGE_KP_0 : USAGE_0;
      end else if (d < 4'hA) begin
         usage = (keypad ? USAGE_KP_1 : USAGE_1) + {4'h0, d} - 8'h01;
      end else begin
         usage = USAGE_A + {4'h0, d} - 8'h0A;
      end
      return usage;
   endfunction

   function automatic logic [1:0] start_len(input logic [1:0] os);
      logic [1:0] len;
      unique case (os)
         OS_LINUX:   len = 2'd2;
         OS_WINDOWS: len = 2'd3;
         default:    len = 2'd0;
      endcase
      return len;
   endfunction

   function automatic logic [1:0] end_len(input logic [1:0] os);
      logic [1:0] len;
      unique case (os)
         OS_LINUX:   len = 2'd2;
         OS_WINDOWS: len = 2'd1;
         OS_OSX:     len = 2'd1;
         default:    len = 2'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/uks_ctrl.sv]
// ----------------------------------------------------------------------------
// Unicode keystroke sequencer controller
// Walks the start, digit and end phases of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module uks_ctrl
   import uks_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  dp_status_type      status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = status.start_empty ? ST_DIGIT : ST_START;
            end
         end
         ST_START: begin
            cmd.emit_start = 1'b1;
            if (status.start_step_last) begin
               cmd.step_clr = 1'b1;
               state_in     = ST_DIGIT;
            end else begin
               cmd.step_inc = 1'b1;
            end
         end
         ST_DIGIT: begin
            cmd.emit_digit = 1'b1;
            if (status.digit_step_last) begin
               cmd.step_clr   = 1'b1;
               cmd.digit_next = 1'b1;
               if (status.digit_last) begin
                  state_in = status.end_empty ? ST_IDLE : ST_END;
               end
            end else begin
               cmd.step_inc = 1'b1;
            end
         end
         ST_END: begin
            cmd.emit_end = 1'b1;
            if (status.end_step_last) begin
               cmd.step_clr = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.step_inc = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

[hw/rtl/uks_dp.sv]
// ----------------------------------------------------------------------------
// Unicode keystroke sequencer datapath
// Holds the host register, the code point, the counters and the report register.
// ----------------------------------------------------------------------------
`default_nettype none

module uks_dp
   import uks_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [CP_W-1:0] req_code_point,
   input  wire logic            csr_we,
   input  wire logic [1:0]      csr_wdata,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_modifier_set,
   output logic [7:0]           rsp_key_usage,
   output logic                 rsp_last_report
);

   logic [1:0]        host_os_ff;
   logic [1:0]        host_os_in;
   logic [HOLD_W-1:0] cp_ff;
   logic [HOLD_W-1:0] cp_in;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  idx_in;
   logic [1:0]        step_ff;
   logic [1:0]        step_in;
   logic              valid_ff;
   logic              valid_in;
   logic [2:0]        mod_ff;
   logic [2:0]        mod_in;
   logic [7:0]        key_ff;
   logic [7:0]        key_in;
   logic              last_ff;
   logic              last_in;

   logic [IDX_W-1:0]  top_idx;
   logic [NIB_W-1:0]  nib [HEX_DIGITS];
   logic [NIB_W-1:0]  cur_nib;
   logic [2:0]        held;
   logic [1:0]        s_len;
   logic [1:0]        e_len;

   always_comb begin
      top_idx = IDX_W'(MIN_DIGITS - 1);
      for (int i = 0; i < HEX_DIGITS; i++) begin
         if ((i >= MIN_DIGITS) && (req_code_point[i*NIB_W +: NIB_W] != '0)) begin
            top_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < HEX_DIGITS; i++) begin
         nib[i] = cp_ff[i*NIB_W +: NIB_W];
      end
   end

   assign cur_nib = nib[idx_ff];
   assign s_len   = start_len(host_os_ff);
   assign e_len   = end_len(host_os_ff);
   assign held    = ((host_os_ff == OS_WINDOWS) || (host_os_ff == OS_OSX)) ? MOD_ALT : MOD_NONE;

   always_comb begin
      status.start_empty     = (s_len == 2'd0);
      status.end_empty       = (e_len == 2'd0);
      status.digit_last      = (idx_ff == '0);
      status.start_step_last = (step_ff == s_len - 2'd1);
      status.digit_step_last = (step_ff == 2'd1);
      status.end_step_last   = (step_ff == e_len - 2'd1);
   end

   always_comb begin
      host_os_in = csr_we ? csr_wdata : host_os_ff;
      cp_in      = cmd.load ? req_code_point[HOLD_W-1:0] : cp_ff;
      idx_in     = idx_ff;
      if (cmd.load) begin
         idx_in = top_idx;
      end else if (cmd.digit_next) begin
         idx_in = idx_ff - IDX_W'(1);
      end
      step_in = step_ff;
      if (cmd.step_clr || cmd.load) begin
         step_in = 2'd0;
      end else if (cmd.step_inc) begin
         step_in = step_ff + 2'd1;
      end
   end

   always_comb begin
      mod_in = MOD_NONE;
      key_in = USAGE_NONE;
      if (cmd.emit_start) begin
         if (host_os_ff == OS_LINUX) begin
            if (step_ff == 2'd0) begin
               mod_in = MOD_CTRL | MOD_SHIFT;
               key_in = USAGE_U;
            end
         end else begin
            mod_in = MOD_ALT;
            if (step_ff == 2'd1) begin
               key_in = USAGE_KP_ADD;
            end
         end
      end else if (cmd.emit_digit) begin
         mod_in = held;
         if (step_ff == 2'd0) begin
            key_in = digit_usage(cur_nib, host_os_ff == OS_WINDOWS);
         end
      end else if (cmd.emit_end) begin
         if ((host_os_ff == OS_LINUX) && (step_ff == 2'd0)) begin
            key_in = USAGE_SPACE;
         end
      end
      valid_in = cmd.emit_start | cmd.emit_digit | cmd.emit_end;
      last_in  = (cmd.emit_end && status.end_step_last)
               || (cmd.emit_digit && status.digit_step_last && status.digit_last
                   && status.end_empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         host_os_ff <= OS_LINUX;
         idx_ff     <= '0;
         step_ff    <= 2'd0;
         valid_ff   <= 1'b0;
      end else begin
         host_os_ff <= host_os_in;
         idx_ff     <= idx_in;
         step_ff    <= step_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff   <= cp_in;
      mod_ff  <= mod_in;
      key_ff  <= key_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_modifier_set = mod_ff;
   assign rsp_key_usage    = key_ff;
   assign rsp_last_report  = last_ff;

endmodule

`default_nettype wire

[hw/rtl/unicode_keystroke_sequencer.sv]
// ----------------------------------------------------------------------------
// Unicode keystroke sequencer
// Turns one code point into the keyboard reports that type it on a host.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low; the code
// point is sampled on req_code_point at that edge. The block then emits its
// run of reports, one per cycle, each shown for one cycle with rsp_valid
// high; rsp_last_report marks the final one. At the accepting edge the
// controller leaves idle; the report register then loads the first report.
// A run is 8 to 20 reports: the host start sequence, two reports per hex
// digit (at least four digits, leading zeros dropped) and the host end
// sequence. Busy stays high while the controller walks its phases and is
// low again when the final report is shown, so the next request can be
// taken while that report is on the ports. The receiver cannot stall;
// every report must be taken when shown. The host system is written
// through csr_we and csr_wdata; the user must do so only while idle, as
// the block does not enforce it. Reset returns the controller to idle,
// clears the output strobe and sets the host system to linux.
// ----------------------------------------------------------------------------
`default_nettype none
`include "unicode_keystroke_sequencer_defines.svh"

module unicode_keystroke_sequencer
   import uks_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire logic [CP_W-1:0] req_code_point,
   input  wire logic            csr_we,
   input  wire logic [1:0]      csr_wdata,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_modifier_set,
   output logic [7:0]           rsp_key_usage,
   output logic                 rsp_last_report
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   uks_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   uks_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_code_point   (req_code_point),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_modifier_set (rsp_modifier_set),
      .rsp_key_usage    (rsp_key_usage),
      .rsp_last_report  (rsp_last_report)
   );

   `UKS_ASSERT_SAME(a_last_when_idle, clock, reset, rsp_valid && rsp_last_report, !busy)
   `UKS_ASSERT_SAME(a_last_is_valid, clock, reset, rsp_last_report, rsp_valid)
   `UKS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid)
   `UKS_ASSERT_NEXT(a_busy_emits, clock, reset, busy && $past(busy), rsp_valid)

endmodule

`default_nettype wire

[verif/tb_unicode_keystroke_sequencer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Unicode keystroke sequencer testbench
// Drives code point requests under every host setting and checks each
// keyboard report against a predicted run, in order, with random gaps
// between requests.
// ----------------------------------------------------------------------------
module tb_unicode_keystroke_sequencer;
   import uks_pkg::*;

   localparam int MAX_RUN       = 20;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 51;
   localparam int TAIL_CYCLES   = 40;

   typedef struct packed {
      logic [2:0] mods;
      logic [7:0] key;
      logic       last;
   } key_report_type;

   class keystroke_scoreboard;
      logic [1:0]     host_os;
      key_report_type pending_reports[$];

      function new();
         host_os = OS_LINUX;
      endfunction

      function void set_host(logic [1:0] os);
         host_os = os;
      endfunction

      function int outstanding();
         return pending_reports.size();
      endfunction

      function key_report_type make_report(logic [2:0] mods, logic [7:0] key);
         key_report_type r;
         r.mods = mods;
         r.key  = key;
         r.last = 1'b0;
         return r;
      endfunction

      function logic [7:0] digit_key(logic [3:0] d, bit keypad);
         if (d == 4'h0) begin
            return keypad ? USAGE_KP_0 : USAGE_0;
         end
         if (d < 4'hA) begin
            return (keypad ? USAGE_KP_1 : USAGE_1) + 8'(d) - 8'h01;
         end
         return USAGE_A + 8'(d - 4'hA);
      endfunction

      function void note_request(logic [31:0] code_point);
         key_report_type run[$];
         logic [2:0]     held;
         logic [3:0]     nib;
         bit             keypad;
         bit             leading;
         keypad  = (host_os == OS_WINDOWS);
         held    = (host_os == OS_WINDOWS || host_os == OS_OSX) ? MOD_ALT : MOD_NONE;
         leading = 1'b1;
         case (host_os)
            OS_LINUX: begin
               run.push_back(make_report(MOD_CTRL | MOD_SHIFT, USAGE_U));
               run.push_back(make_report(MOD_NONE, USAGE_NONE));
            end
            OS_WINDOWS: begin
               run.push_back(make_report(MOD_ALT, USAGE_NONE));
               run.push_back(make_report(MOD_ALT, USAGE_KP_ADD));
               run.push_back(make_report(MOD_ALT, USAGE_NONE));
            end
            default: begin
            end
         endcase
         for (int i = HEX_DIGITS - 1; i >= 0; i--) begin
            nib = code_point[4*i +: 4];
            if (i < MIN_DIGITS) begin
               leading = 1'b0;
            end
            if (!(nib == 4'h0 && leading)) begin
               leading = 1'b0;
               if (run.size() + 2 <= MAX_RUN) begin
                  run.push_back(make_report(held, digit_key(nib, keypad)));
                  run.push_back(make_report(held, USAGE_NONE));
               end
            end
         end
         case (host_os)
            OS_LINUX: begin
               run.push_back(make_report(MOD_NONE, USAGE_SPACE));
               run.push_back(make_report(MOD_NONE, USAGE_NONE));
            end
            OS_WINDOWS, OS_OSX: begin
               run.push_back(make_report(MOD_NONE, USAGE_NONE));
            end
            default: begin
            end
         endcase
         run[run.size() - 1].last = 1'b1;
         foreach (run[k]) begin
            pending_reports.push_back(run[k]);
         end
      endfunction

      function string check_report(logic [2:0] mods, logic [7:0] key, logic last);
         key_report_type want;
         if (pending_reports.size() == 0) begin
            return $sformatf("unexpected report mods=%0h key=%02h last=%0b",
                             mods, key, last);
         end
         want = pending_reports.pop_front();
         if (mods !== want.mods || key !== want.key || last !== want.last) begin
            return $sformatf({"report mismatch: got mods=%0h key=%02h last=%0b, ",
                              "want mods=%0h key=%02h last=%0b"},
                             mods, key, last, want.mods, want.key, want.last);
         end
         return "";
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_code_point;
   logic        csr_we;
   logic [1:0]  csr_wdata;
   logic        rsp_valid;
   logic [2:0]  rsp_modifier_set;
   logic [7:0]  rsp_key_usage;
   logic        rsp_last_report;

   keystroke_scoreboard scoreboard = new();
   int  err_count      = 0;
   int  requests_taken = 0;
   bit  idle_enabled   = 1'b1;

   unicode_keystroke_sequencer dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_code_point  (req_code_point),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_modifier_set(rsp_modifier_set),
      .rsp_key_usage   (rsp_key_usage),
      .rsp_last_report (rsp_last_report)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(string msg);
      $display("%0t: %s", $time, msg);
      err_count++;
   endtask

   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         if (csr_we) begin
            scoreboard.set_host(csr_wdata);
         end
         if (start && !busy) begin
            scoreboard.note_request(req_code_point);
            requests_taken++;
         end
         if (rsp_valid) begin
            msg = scoreboard.check_report(rsp_modifier_set, rsp_key_usage, rsp_last_report);
            if (msg != "") begin
               report_mismatch(msg);
            end
         end
      end
   end

   task automatic send_request(logic [31:0] code_point);
      int taken;
      if (idle_enabled && $urandom_range(0, 99) < 14) begin
         start <= 1'b0;
         req_code_point <= $urandom;
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
      start <= 1'b1;
      req_code_point <= code_point;
      taken = requests_taken;
      do @(negedge clock); while (requests_taken == taken);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (scoreboard.outstanding() != 0 || busy);
   endtask

   task automatic write_host(logic [1:0] os);
      csr_we <= 1'b1;
      csr_wdata <= os;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] random_code_point();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return 32'h0;
         1, 2, 3: return $urandom;
         9:       return $urandom & 32'h0000_FFFF;
         default: return $urandom >> (4 * $urandom_range(1, 7));
      endcase
   endfunction

   initial begin
      logic [31:0] directed[6];
      logic [1:0]  os_order[4];
      logic [1:0]  phase_os;
      int          drain_at;
      directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0123_4567,
                   32'h89AB_CDEF, 32'h0001_0000, 32'h000A_BCDE};
      os_order = '{OS_LINUX, OS_WINDOWS, OS_OSX, OS_OTHER};
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_code_point = '0;
      csr_we = 1'b0;
      csr_wdata = OS_LINUX;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (os_order[o]) begin
         write_host(os_order[o]);
         foreach (directed[k]) begin
            send_request(directed[k]);
         end
         wait_drained();
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            phase_os = OS_OTHER;
         end else if (p == 1) begin
            phase_os = OS_LINUX;
         end else begin
            phase_os = 2'($urandom_range(0, 3));
         end
         idle_enabled = (p != 2);
         drain_at = $urandom_range(5, PHASE_ITEMS - 5);
         write_host(phase_os);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == drain_at) begin
               wait_drained();
            end
            send_request(random_code_point());
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (scoreboard.outstanding() != 0) begin
         report_mismatch($sformatf("%0d reports never arrived", scoreboard.outstanding()));
      end
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[unicode_keystroke_sequencer.f]
+incdir+hw/rtl
hw/rtl/uks_pkg.sv
hw/rtl/uks_ctrl.sv
hw/rtl/uks_dp.sv
hw/rtl/unicode_keystroke_sequencer.sv
verif/tb_unicode_keystroke_sequencer.sv
